### rtl/sha256_pkg.sv
// Package: SHA-256 stream hasher types, constants and round functions.
package sha256_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS      = 64;
    localparam int DIGEST_WORDS = 8;

    // Entry passed from the byte front end to the compression back end
    typedef struct packed {
        logic        last_block;  // final block of the message
    } blk_ctl_t;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_LOAD,
        BE_ROUND,
        BE_ADD,
        BE_OUT
    } be_state_t;

    typedef enum logic [1:0] {
        FE_ACCEPT,
        FE_PAD_A,
        FE_PAD_B
    } fe_state_t;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffe; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] initial_h(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

### rtl/sha256_front.sv
// Front end: collects bytes into a double-buffered block store and pads.
module sha256_front
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        is_last,
    // queue to back end: one slot per buffer
    output logic [1:0]  buf_full,
    output blk_ctl_t    buf_ctl [2],
    input  logic [1:0]  buf_release,
    // back end read port
    input  logic        rd_buf,
    input  logic [3:0]  rd_word,
    output logic [31:0] rd_data
);

    // Two buffers of 16 big-endian words; buffer index is the top address bit
    logic [31:0] store_mem [2*BLOCK_BYTES/4];
    fe_state_t   state_reg, state_next;
    logic        wbuf_reg, wbuf_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [1:0]  full_reg, full_next;
    logic        pend_reg, pend_next;
    blk_ctl_t    ctl_reg [2];
    logic        we;
    logic [5:0]  waddr;
    logic [7:0]  wdata;
    logic        close_blk;
    blk_ctl_t    close_ctl;
    logic        take;
    logic        buf_free;
    logic [63:0] len_bits;

    assign buf_full = full_reg;
    assign buf_ctl  = ctl_reg;
    assign take     = in_valid && in_ready;
    assign buf_free = !full_reg[wbuf_reg];
    assign len_bits = bits_reg + {55'd0, fill_reg, 3'd0};

    // Byte and padding writes into the current buffer
    always_comb
    begin
        state_next = state_reg;
        wbuf_next  = wbuf_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        pend_next  = pend_reg;
        full_next  = full_reg & ~buf_release;
        in_ready   = 1'b0;
        we         = 1'b0;
        waddr      = fill_reg;
        wdata      = data_byte;
        close_blk  = 1'b0;
        close_ctl  = '0;
        case (state_reg)
            FE_ACCEPT:
            begin
                in_ready = buf_free;
                if (take && has_byte)
                begin
                    we = 1'b1;
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        close_blk = 1'b1;
                        bits_next = bits_reg + 64'd512;
                    end
                end
                if (take && is_last)
                    state_next = FE_PAD_A;
            end
            FE_PAD_A:
            begin
                // 0x80 marker once the write buffer is free, bit length latched
                if (buf_free)
                begin
                    bits_next  = len_bits;
                    we         = 1'b1;
                    wdata      = 8'h80;
                    fill_next  = fill_reg + 6'd1;
                    state_next = FE_PAD_B;
                    // marker at bytes 56..62 leaves no room for the length
                    pend_next  = (fill_reg > 6'd55) && (fill_reg != 6'd63);
                    if (fill_reg == 6'd63)
                        close_blk = 1'b1;
                end
            end
            FE_PAD_B:
            begin
                if (buf_free)
                begin
                    we = 1'b1;
                    if (fill_reg >= 6'd56 && !pend_reg)
                        wdata = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
                    else
                        wdata = 8'h00;
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        close_blk = 1'b1;
                        close_ctl.last_block = !pend_reg;
                        pend_next = 1'b0;
                    end
                end
            end
            default: state_next = FE_ACCEPT;
        endcase
        if (close_blk)
        begin
            full_next[wbuf_reg] = 1'b1;
            wbuf_next = !wbuf_reg;
            if (close_ctl.last_block)
            begin
                state_next = FE_ACCEPT;
                bits_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_ACCEPT;
            wbuf_reg  <= 1'b0;
            fill_reg  <= '0;
            bits_reg  <= '0;
            full_reg  <= '0;
            pend_reg  <= 1'b0;
            ctl_reg[0] <= '0;
            ctl_reg[1] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wbuf_reg  <= wbuf_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            full_reg  <= full_next;
            pend_reg  <= pend_next;
            if (close_blk)
                ctl_reg[wbuf_reg] <= close_ctl;
        end
    end

    // Block store: byte-lane write, registered word read
    always_ff @(posedge clk)
    begin
        if (we)
            store_mem[{wbuf_reg, waddr[5:2]}][{~waddr[1:0], 3'b000} +: 8] <= wdata;
        rd_data <= store_mem[{rd_buf, rd_word}];
    end

    ast_no_ready_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg == 2'b11) |-> !in_ready) else $error("accept with both buffers full");
    ast_close_sets_full: assert property (@(posedge clk) disable iff (!rst_n)
        close_blk |=> full_reg[$past(wbuf_reg)]) else $error("closed block not queued");
    ast_pad_no_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != FE_ACCEPT) |-> !in_ready) else $error("input taken during padding");

endmodule

### rtl/sha256_back.sv
// Back end: 64-round compression of queued blocks and digest output.
module sha256_back
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  buf_full,
    input  blk_ctl_t    buf_ctl [2],
    output logic [1:0]  buf_release,
    output logic        rd_buf,
    output logic [3:0]  rd_word,
    input  logic [31:0] rd_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    be_state_t   state_reg, state_next;
    logic        rbuf_reg;
    logic [6:0]  cnt_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic        last_reg;
    logic [31:0] wt, s0, s1, t1, t2;
    logic        ready_blk;

    assign rd_buf    = rbuf_reg;
    assign rd_word   = cnt_reg[3:0];
    assign ready_blk = buf_full[rbuf_reg];

    // Message schedule word and round terms for the current round
    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wt = (cnt_reg < 7'd16) ? w_reg[0] : (w_reg[0] + s0 + w_reg[9] + s1);
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + round_k(cnt_reg[5:0]) + wt;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb
    begin
        state_next  = state_reg;
        buf_release = '0;
        out_valid   = (state_reg == BE_OUT);
        case (state_reg)
            BE_IDLE:  if (ready_blk) state_next = BE_LOAD;
            BE_LOAD:  if (cnt_reg == 7'd16) state_next = BE_ROUND;
            BE_ROUND: if (cnt_reg == 7'd63) state_next = BE_ADD;
            BE_ADD:
            begin
                buf_release[rbuf_reg] = 1'b1;
                state_next = last_reg ? BE_OUT : BE_IDLE;
            end
            BE_OUT:
                if (out_ready && cnt_reg[2:0] == 3'd7) state_next = BE_IDLE;
            default: state_next = BE_IDLE;
        endcase
    end

    assign digest_word = h_reg[cnt_reg[2:0]];
    assign word_index  = cnt_reg[2:0];
    assign last_word   = (cnt_reg[2:0] == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BE_IDLE;
            rbuf_reg  <= 1'b0;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= initial_h(3'(i));
                v_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++)
                w_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                BE_IDLE:
                begin
                    cnt_reg <= '0;
                    last_reg <= buf_ctl[rbuf_reg].last_block;
                    for (int i = 0; i < 8; i++)
                        v_reg[i] <= h_reg[i];
                end
                BE_LOAD:
                begin
                    // read data is registered and lags the address, so nothing is captured at count zero
                    if (cnt_reg != 7'd0)
                    begin
                        for (int i = 0; i < 15; i++)
                            w_reg[i] <= w_reg[i+1];
                        w_reg[15] <= rd_data;
                    end
                    cnt_reg <= (cnt_reg == 7'd16) ? 7'd0 : cnt_reg + 7'd1;
                end
                BE_ROUND:
                begin
                    for (int i = 0; i < 15; i++)
                        w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= wt;
                    v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    cnt_reg <= cnt_reg + 7'd1;
                end
                BE_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    rbuf_reg <= !rbuf_reg;
                    cnt_reg  <= '0;
                end
                BE_OUT:
                    if (out_ready)
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                        if (cnt_reg[2:0] == 3'd7)
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= initial_h(3'(i));
                    end
                default: cnt_reg <= '0;
            endcase
        end
    end

    ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(word_index) && $stable(digest_word)))
        else $error("digest word changed while stalled");
    ast_release_full: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_release != 2'b00) |-> ((buf_release & buf_full) == buf_release))
        else $error("release of empty buffer");
    ast_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BE_ROUND) |-> (cnt_reg < 7'd64)) else $error("round overrun");

endmodule

### rtl/sha256_stream_hasher.sv
// Top level: SHA-256 over a byte stream, digest out as eight words.
// Each transaction carries at most one byte, and one is taken per cycle while
// the write buffer is free. Bytes go into one of two 64-byte buffers while
// the other is compressed. A block passes through the round unit as an idle
// step, a load of 16 words behind the registered read, 64 rounds and one
// add; once both buffers are full, input waits until the back end releases
// one. After the final transaction the front end writes padding one byte per
// cycle while the write buffer is free, up to the end of the tail's block, or
// of the next block when the tail is 56 bytes or more; no input is taken
// meanwhile. The eight digest words, H0 first, follow the compression of the
// last block and are held until taken; no further block is compressed before
// the eighth word is taken.
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    logic [1:0]  buf_full, buf_release;
    blk_ctl_t    buf_ctl [2];
    logic        rd_buf;
    logic [3:0]  rd_word;
    logic [31:0] rd_data;

    sha256_front u_front (
        .clk, .rst_n,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .data_byte(s_tdata), .has_byte(s_tuser), .is_last(s_tlast),
        .buf_full, .buf_ctl, .buf_release,
        .rd_buf, .rd_word, .rd_data
    );

    sha256_back u_back (
        .clk, .rst_n,
        .buf_full, .buf_ctl, .buf_release,
        .rd_buf, .rd_word, .rd_data,
        .out_valid(m_tvalid), .out_ready(m_tready),
        .digest_word(m_tdata), .word_index(m_tuser), .last_word(m_tlast)
    );

endmodule

### test/tb.sv
// Testbench for the SHA-256 stream hasher: directed and random messages against a local predictor.
`timescale 1ns / 100ps

module tb;
    import sha256_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // has_byte
    logic        s_tlast;   // is_last
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] digest_word
    logic [2:0]  m_tuser;   // [2:0] word_index
    logic        m_tlast;   // last_word

    // Predictor state
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int unsigned block_fill;
    logic [63:0] bit_count;

    digest_item_t digest_queue [$];
    int          fail_count;
    int          items_sent;
    int          rx_gap;
    bit          hold_off;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffe, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    sha256_stream_hasher dut (.*);

    always #5 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of msg_block into hash_state
    task automatic compress_msg_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++)
        begin
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int t = 0; t < 64; t++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + K_TAB[t] + w[t];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic restart_message();
        hash_state = H_INIT;
        block_fill = 0;
        bit_count = '0;
    endtask

    // Update predictor for one accepted transaction
    task automatic predict_digest(logic [7:0] data, logic has_byte, logic is_last);
        digest_item_t it;
        int unsigned pos;
        if (has_byte)
        begin
            msg_block[block_fill] = data;
            block_fill++;
            if (block_fill == 64)
            begin
                compress_msg_block();
                bit_count += 64'd512;
                block_fill = 0;
            end
        end
        if (!is_last)
            return;
        bit_count += 64'(block_fill * 8);
        pos = block_fill;
        msg_block[pos] = 8'h80;
        pos++;
        if (pos > 56)
        begin
            while (pos < 64)
                msg_block[pos++] = 8'h00;
            compress_msg_block();
            pos = 0;
        end
        while (pos < 56)
            msg_block[pos++] = 8'h00;
        for (int j = 0; j < 8; j++)
            msg_block[63-j] = bit_count[8*j +: 8];
        compress_msg_block();
        for (int j = 0; j < 8; j++)
        begin
            it.word = hash_state[j];
            it.idx = 3'(j);
            it.last = (j == 7);
            digest_queue.push_back(it);
        end
        restart_message();
    endtask

    // Send one transaction, with a random gap before it
    task automatic send_byte(logic [7:0] data, logic has_byte, logic is_last);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        predict_digest(data, has_byte, is_last);
    endtask

    task automatic send_message(int len, bit empty_tail);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 31) == 0)
                send_byte(8'($urandom), 1'b0, 1'b0);   // idle transaction
            send_byte(8'($urandom), 1'b1, (i == len - 1) && !empty_tail);
        end
        if (empty_tail || len == 0)
            send_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    // Receiver: random back-pressure with occasional long gaps, or a long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end
        else if (hold_off)
            m_tready <= 1'b0;
        else if (rx_gap > 0)
        begin
            m_tready <= 1'b0;
            rx_gap   <= rx_gap - 1;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            m_tready <= 1'b0;
            rx_gap   <= $urandom_range(10, 40);
        end
        else
            m_tready <= ($urandom_range(0, 2) != 0);
    end

    // Result checker
    always @(posedge clk)
    begin
        digest_item_t exp_item;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_queue.size() == 0)
            begin
                $display("%0t: unexpected digest word %h idx %0d", $time, m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                exp_item = digest_queue.pop_front();
                if (m_tdata !== exp_item.word || m_tuser !== exp_item.idx
                    || m_tlast !== exp_item.last)
                begin
                    $display("%0t: mismatch expected word %h idx %0d last %b, got %h %0d %b",
                        $time, exp_item.word, exp_item.idx, exp_item.last,
                        m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Long receiver stall while the sender keeps feeding
    task automatic hold_receiver();
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
    endtask

    task automatic test_directed();
        send_byte(8'h00, 1'b0, 1'b1);                 // empty message
        send_byte(8'h61, 1'b1, 1'b0);                 // "abc"
        send_byte(8'h62, 1'b1, 1'b0);
        send_byte(8'h63, 1'b1, 1'b1);
        send_byte(8'hff, 1'b0, 1'b0);                 // idle only
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h5a, 1'b0, 1'b1);                 // empty final item
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hff, 1'b1, 1'b1);
    endtask

    // Padding boundaries while the digest output is held, so both buffers fill
    task automatic test_backpressure();
        fork
            hold_receiver();
            begin
                send_message(62, 1);   // marker at byte 62, length in a second block
                send_message(64, 0);   // exact block, padding in a block of its own
                send_message(3, 0);    // both buffers full: input stalls here
            end
        join
    endtask

    task automatic test_random();
        int len;
        while (items_sent < 165)
        begin
            len = $urandom_range(0, 8);
            send_message(len, $urandom_range(0, 3) == 0);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        hold_off = 1'b0;
        fail_count = 0;
        items_sent = 0;
        for (int i = 0; i < 64; i++)
            msg_block[i] = 8'h00;
        restart_message();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random();
        s_tvalid <= 1'b0;

        // Drain outstanding digests
        while (digest_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/sha256_pkg.sv
rtl/sha256_front.sv
rtl/sha256_back.sv
rtl/sha256_stream_hasher.sv
test/tb.sv
